/* rtl/cfrc_pkg.sv */
`timescale 1ns / 1ps

package cfrc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH = 32;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    SCAN_OK       = 2'd0,
    SCAN_READ_ERR = 2'd1,
    SCAN_UNTERM   = 2'd2
  } scan_status_t;

  typedef struct packed {
    scan_status_t           status;
    logic [TOTAL_WIDTH-1:0] field_total;
    logic [TOTAL_WIDTH-1:0] record_total;
  } scan_result_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
  endfunction

endpackage

/* rtl/cfrc_scan.sv */
`timescale 1ns / 1ps

module cfrc_scan import cfrc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         end_of_stream,
  input  logic         read_failed,
  output logic         res_valid,
  output scan_result_t res
);

  logic   inside_quotes_r, inside_quotes_nxt;
  logic   quote_pending_r, quote_pending_nxt;
  logic   record_open_r, record_open_nxt;
  logic   field_nonempty_r, field_nonempty_nxt;
  count_t field_counter_r, field_counter_nxt;
  count_t record_counter_r, record_counter_nxt;

  logic   is_quote;
  logic   outside_path;
  count_t fc_end;
  count_t rc_end;

  assign is_quote = (data_byte == CH_QUOTE);

  always_comb begin
    inside_quotes_nxt  = inside_quotes_r;
    quote_pending_nxt  = quote_pending_r;
    record_open_nxt    = record_open_r;
    field_nonempty_nxt = field_nonempty_r;
    field_counter_nxt  = field_counter_r;
    record_counter_nxt = record_counter_r;
    outside_path       = 1'b0;
    fc_end             = field_counter_r;
    rc_end             = record_counter_r;
    res_valid          = 1'b0;
    res.status         = SCAN_OK;

    if (end_of_stream) begin
      if (read_failed) begin
        res.status = SCAN_READ_ERR;
      end else if (inside_quotes_r && !quote_pending_r) begin
        res.status = SCAN_UNTERM;
      end else if (record_open_r) begin
        fc_end = sat_inc(field_counter_r);
        rc_end = sat_inc(record_counter_r);
      end
      res_valid          = accept;
      inside_quotes_nxt  = 1'b0;
      quote_pending_nxt  = 1'b0;
      record_open_nxt    = 1'b0;
      field_nonempty_nxt = 1'b0;
      field_counter_nxt  = '0;
      record_counter_nxt = '0;
    end else begin
      record_open_nxt = 1'b1;
      if (inside_quotes_r) begin
        if (quote_pending_r) begin
          quote_pending_nxt = 1'b0;
          if (is_quote) begin
            field_nonempty_nxt = 1'b1;
          end else begin
            inside_quotes_nxt = 1'b0;
            outside_path      = 1'b1;
          end
        end else if (is_quote) begin
          quote_pending_nxt = 1'b1;
        end else begin
          field_nonempty_nxt = 1'b1;
        end
      end else begin
        outside_path = 1'b1;
      end

      if (outside_path) begin
        if (is_quote && !field_nonempty_r) begin
          inside_quotes_nxt  = 1'b1;
          field_nonempty_nxt = 1'b1;
        end else if (data_byte == CH_COMMA) begin
          field_counter_nxt  = sat_inc(field_counter_r);
          field_nonempty_nxt = 1'b0;
        end else if (data_byte == CH_LF) begin
          field_counter_nxt  = sat_inc(field_counter_r);
          record_counter_nxt = sat_inc(record_counter_r);
          record_open_nxt    = 1'b0;
          field_nonempty_nxt = 1'b0;
        end else if (data_byte != CH_CR) begin
          field_nonempty_nxt = 1'b1;
        end
      end
    end

    res.field_total  = TOTAL_WIDTH'(fc_end);
    res.record_total = TOTAL_WIDTH'(rc_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_quotes_r  <= 1'b0;
      quote_pending_r  <= 1'b0;
      record_open_r    <= 1'b0;
      field_nonempty_r <= 1'b0;
      field_counter_r  <= '0;
      record_counter_r <= '0;
    end else if (accept) begin
      inside_quotes_r  <= inside_quotes_nxt;
      quote_pending_r  <= quote_pending_nxt;
      record_open_r    <= record_open_nxt;
      field_nonempty_r <= field_nonempty_nxt;
      field_counter_r  <= field_counter_nxt;
      record_counter_r <= record_counter_nxt;
    end
  end

endmodule

/* rtl/cfrc_out_reg.sv */
`timescale 1ns / 1ps

module cfrc_out_reg import cfrc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  scan_result_t load_data,
  input  logic         out_ready,
  output logic         out_valid,
  output logic         has_room,
  output scan_result_t out_data
);

  logic         valid_r, valid_nxt;
  scan_result_t data_r;

  assign has_room  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

/* rtl/csv_field_record_counter_core.sv */
`timescale 1ns / 1ps
// a result word is registered and appears in the cycle after its end-of-stream word is accepted
// throughput: one input word per cycle while the result slot is empty or being drained
// any input word waits while an earlier result is still held by the sink
// reset (rst_n low, synchronous) clears quote/record state, both counters and out_valid

module csv_field_record_counter_core import cfrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_stream,
  input  logic                   in_read_failed,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_scan_status,
  output logic [TOTAL_WIDTH-1:0] out_field_total,
  output logic [TOTAL_WIDTH-1:0] out_record_total
);

  logic         accept;
  logic         res_valid;
  logic         has_room;
  scan_result_t res;
  scan_result_t out_data;

  assign in_ready = has_room;
  assign accept   = in_valid && has_room;

  cfrc_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .read_failed   (in_read_failed),
    .res_valid     (res_valid),
    .res           (res)
  );

  cfrc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .has_room  (has_room),
    .out_data  (out_data)
  );

  assign out_scan_status  = out_data.status;
  assign out_field_total  = out_data.field_total;
  assign out_record_total = out_data.record_total;

endmodule

/* rtl/cfrc_checker.sv */
`timescale 1ns / 1ps

module cfrc_checker import cfrc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_end_of_stream,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             out_scan_status,
  input logic [TOTAL_WIDTH-1:0] out_field_total,
  input logic [TOTAL_WIDTH-1:0] out_record_total
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scan_status)
      && $stable(out_field_total) && $stable(out_record_total))
    else $error("result word changed while stalled");

  // single result slot: no intake while it is full and stalled
  a_no_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result slot blocked");

  // end word gives a result next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_stream |=> out_valid)
    else $error("end word produced no result");

  // data word never produces a result
  a_data_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_end_of_stream && (!out_valid || out_ready) |=> !out_valid)
    else $error("result without end word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scan_status != 2'd3)
    else $error("illegal status code");

endmodule

bind csv_field_record_counter_core cfrc_checker u_cfrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_end_of_stream (in_end_of_stream),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_scan_status  (out_scan_status),
  .out_field_total  (out_field_total),
  .out_record_total (out_record_total)
);

/* bench/csv_scan_checker.sv */
`timescale 1ns / 1ps

module csv_scan_checker import cfrc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_stream,
  input  logic                   in_read_failed,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             out_scan_status,
  input  logic [TOTAL_WIDTH-1:0] out_field_total,
  input  logic [TOTAL_WIDTH-1:0] out_record_total,
  output int                     fail_count,
  output int                     results_due
);

  bit     in_quotes;
  bit     quote_wait;
  bit     rec_open;
  bit     fld_data;
  count_t n_fields;
  count_t n_records;
  int     fails;

  scan_result_t status_words[$];

  function automatic count_t bump(input count_t v);
    bump = (&v) ? v : v + count_t'(1);
  endfunction

  task automatic clear_scan();
    in_quotes  = 1'b0;
    quote_wait = 1'b0;
    rec_open   = 1'b0;
    fld_data   = 1'b0;
    n_fields   = '0;
    n_records  = '0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    rec_open = 1'b1;
    if (in_quotes) begin
      if (quote_wait) begin
        if (b == CH_QUOTE) begin
          quote_wait = 1'b0;
          fld_data   = 1'b1;
          return;
        end
        in_quotes  = 1'b0;
        quote_wait = 1'b0;
      end else if (b == CH_QUOTE) begin
        quote_wait = 1'b1;
        return;
      end else begin
        fld_data = 1'b1;
        return;
      end
    end
    if (b == CH_QUOTE && !fld_data) begin
      in_quotes = 1'b1;
      fld_data  = 1'b1;
    end else if (b == CH_COMMA) begin
      n_fields = bump(n_fields);
      fld_data = 1'b0;
    end else if (b == CH_LF) begin
      n_fields  = bump(n_fields);
      n_records = bump(n_records);
      rec_open  = 1'b0;
      fld_data  = 1'b0;
    end else if (b != CH_CR) begin
      fld_data = 1'b1;
    end
  endtask

  task automatic close_stream(input logic read_err);
    scan_result_t r;
    r.status = SCAN_OK;
    if (read_err) begin
      r.status = SCAN_READ_ERR;
    end else if (in_quotes && !quote_wait) begin
      r.status = SCAN_UNTERM;
    end else if (rec_open) begin
      n_fields  = bump(n_fields);
      n_records = bump(n_records);
    end
    r.field_total  = TOTAL_WIDTH'(n_fields);
    r.record_total = TOTAL_WIDTH'(n_records);
    status_words.push_back(r);
    clear_scan();
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      clear_scan();
      status_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word: status %0d fields %0d records %0d",
                   $time, out_scan_status, out_field_total, out_record_total);
        end else begin
          want = status_words.pop_front();
          if (scan_status_t'(out_scan_status) != want.status) begin
            fails++;
            $display("%0t: scan_status expected %0d actual %0d",
                     $time, want.status, out_scan_status);
          end
          if (out_field_total != want.field_total) begin
            fails++;
            $display("%0t: field_total expected %0d actual %0d",
                     $time, want.field_total, out_field_total);
          end
          if (out_record_total != want.record_total) begin
            fails++;
            $display("%0t: record_total expected %0d actual %0d",
                     $time, want.record_total, out_record_total);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_end_of_stream) begin
          close_stream(in_read_failed);
        end else begin
          scan_byte(in_data_byte);
        end
      end
    end
    fail_count  <= fails;
    results_due <= status_words.size();
  end

endmodule

/* bench/tb_csv_field_record_counter_core.sv */
`timescale 1ns / 1ps

module tb_csv_field_record_counter_core;
  import cfrc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 1600;
  localparam int CALM_AFTER   = 1400;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_data_byte     = 8'h00;
  logic                   in_end_of_stream = 1'b0;
  logic                   in_read_failed   = 1'b0;
  logic                   out_valid;
  logic                   out_ready        = 1'b0;
  logic [1:0]             out_scan_status;
  logic [TOTAL_WIDTH-1:0] out_field_total;
  logic [TOTAL_WIDTH-1:0] out_record_total;

  int fail_count;
  int results_due;
  int words_sent = 0;
  int cycles     = 0;
  int stall_left = 0;
  bit idle_en    = 1'b1;

  always #2 clk = ~clk;

  csv_field_record_counter_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .in_read_failed   (in_read_failed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scan_status  (out_scan_status),
    .out_field_total  (out_field_total),
    .out_record_total (out_record_total)
  );

  csv_scan_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .in_read_failed   (in_read_failed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scan_status  (out_scan_status),
    .out_field_total  (out_field_total),
    .out_record_total (out_record_total),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL csv_field_record_counter_core");
      $finish;
    end
  end

  // sink back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eos, input logic rf);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    in_read_failed   <= rf;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(b, 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_end(input logic rf);
    send_word(8'($urandom_range(0, 255)), 1'b1, rf);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_QUOTE || b == CH_COMMA || b == CH_LF || b == CH_CR) b = 8'h41;
    return b;
  endfunction

  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 9))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_LF;
      3: return CH_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_field(input bit quoted, input bit closed);
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    if (!quoted) begin
      for (int i = 0; i < n; i++) send_byte(plain_byte());
      return;
    end
    send_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          send_byte(CH_QUOTE);
          send_byte(CH_QUOTE);
        end
        1: send_byte(CH_COMMA);
        2: send_byte(CH_LF);
        3: send_byte(CH_CR);
        default: begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE) b = 8'h7A;
          send_byte(b);
        end
      endcase
    end
    if (closed) send_byte(CH_QUOTE);
  endtask

  task automatic put_records();
    int nrec;
    int nfld;
    nrec = $urandom_range(0, 5);
    for (int r = 0; r < nrec; r++) begin
      nfld = $urandom_range(1, 5);
      for (int f = 0; f < nfld; f++) begin
        put_field($urandom_range(0, 2) == 0, 1'b1);
        if (f < nfld - 1) send_byte(CH_COMMA);
      end
      if (r < nrec - 1 || $urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
        send_byte(CH_LF);
      end
    end
  endtask

  task automatic send_stream();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      put_records();
    end else if (kind == 7) begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) send_byte(noisy_byte());
    end else if (kind == 8) begin
      // open quoted field left hanging, sometimes with a quote at the very end
      put_records();
      put_field(1'b1, 1'b0);
      if ($urandom_range(0, 1) == 1) send_byte(CH_QUOTE);
    end else begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0: send_byte(CH_COMMA);
          1: send_byte(CH_LF);
          2: send_byte(CH_CR);
          3: send_byte(CH_QUOTE);
          default: send_byte(8'h61);
        endcase
      end
    end
    send_end($urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stream
    send_end(1'b0);
    // plain fields, a 0xFF byte, crlf ending
    send_word(8'h61, 1'b0, 1'b0);
    send_word(CH_COMMA, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(CH_CR, 1'b0, 1'b0);
    send_word(CH_LF, 1'b0, 1'b0);
    send_end(1'b0);
    // escaped quote, closing quote right before end
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(8'h61, 1'b0, 1'b0);
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(8'h62, 1'b0, 1'b0);
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    // unterminated quote, read_failed on a data word is ignored
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    // read error with an open record and a stray mid-field quote
    send_word(8'h78, 1'b0, 1'b0);
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(8'h79, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    // empty quoted field at end
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(CH_QUOTE, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);

    while (words_sent < RANDOM_WORDS + 24) begin
      if (words_sent < CALM_AFTER) idle_en <= ($urandom_range(0, 4) != 0);
      else idle_en <= 1'b0;
      send_stream();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS csv_field_record_counter_core");
    end else begin
      $display("FAIL csv_field_record_counter_core");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cfrc_pkg.sv
rtl/cfrc_scan.sv
rtl/cfrc_out_reg.sv
rtl/csv_field_record_counter_core.sv
rtl/cfrc_checker.sv
bench/csv_scan_checker.sv
bench/tb_csv_field_record_counter_core.sv
